// File: hw/rtl/tarc_pkg.sv
`default_nettype none

package tarc_pkg;

	// Controller mode codes.
	localparam logic [2:0] MODE_INIT       = 3'd0;
	localparam logic [2:0] MODE_WAIT_FIRST = 3'd1;
	localparam logic [2:0] MODE_IDLE       = 3'd2;
	localparam logic [2:0] MODE_SETTLE     = 3'd3;
	localparam logic [2:0] MODE_HOLD       = 3'd4;
	localparam logic [2:0] MODE_REPEAT_RUN = 3'd5;
	localparam logic [2:0] MODE_REPEAT_DUE = 3'd6;

	// Configuration register indexes.
	localparam logic [1:0] REG_TICKS_PER_SECOND = 2'd0;
	localparam logic [1:0] REG_SETTLE_TICKS     = 2'd1;
	localparam logic [1:0] REG_HOLD_TICKS       = 2'd2;
	localparam logic [1:0] REG_REPEAT_TICKS     = 2'd3;

	// Register values after reset.
	localparam logic [7:0] RST_TICKS_PER_SECOND = 8'd20;
	localparam logic [7:0] RST_SETTLE_TICKS     = 8'd1;
	localparam logic [7:0] RST_HOLD_TICKS       = 8'd10;
	localparam logic [7:0] RST_REPEAT_TICKS     = 8'd2;

	// Pulses produced by one tick.
	typedef struct packed {
		logic advance_second;
		logic step_time;
		logic clear_touch;
	} tarc_pulse_t;

endpackage

`default_nettype wire

// File: hw/rtl/touch_auto_repeat_controller.sv
// Touch auto-repeat controller.
//
// Each input transaction is one timer tick carrying the touch level. Every
// tick produces exactly one output transaction with three pulse fields:
// advance_second, step_time and clear_touch. Both channels use valid/stall;
// a transaction moves on a rising edge with valid high and stall low.
// The tick is captured in an input register, the mode machine and counters
// are evaluated in one short combinational pass, and the pulses land in the
// result register: out_valid rises once the tick has moved from the input
// register into the result register, and one tick is accepted every cycle
// while the output is not stalled.
// When the receiver stalls, the result register holds its pulses and the
// input register fills, after which in_stall rises until the output drains.
// Reset clears the mode to its initial state, zeroes all counters and loads
// the default tick counts (20, 1, 10, 2). The clock starts after one touch.
// Configuration registers are written through cfg_we/cfg_index/cfg_data and
// take effect for ticks processed after the write.
`default_nettype none

module touch_auto_repeat_controller
	import tarc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       touched,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            advance_second,
	output logic            step_time,
	output logic            clear_touch
);

	logic [7:0] ticks_per_second_q;
	logic [7:0] settle_ticks_q;
	logic [7:0] hold_ticks_q;
	logic [7:0] repeat_ticks_q;

	logic [2:0] mode_q;
	logic [7:0] second_count_q;
	logic [7:0] settle_count_q;
	logic [7:0] hold_count_q;
	logic [7:0] repeat_count_q;

	logic        valid_s1;
	logic        touched_s1;
	logic        valid_s2;
	tarc_pulse_t pulse_s2;

	logic        adv_s1;
	logic [2:0]  mode_d;
	logic [7:0]  second_count_d;
	logic [7:0]  settle_count_d;
	logic [7:0]  hold_count_d;
	logic [7:0]  repeat_count_d;
	tarc_pulse_t pulse_d;

	// The tick in stage 1 moves on when the result register is free or drains.
	assign adv_s1   = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv_s1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_per_second_q <= RST_TICKS_PER_SECOND;
			settle_ticks_q     <= RST_SETTLE_TICKS;
			hold_ticks_q       <= RST_HOLD_TICKS;
			repeat_ticks_q     <= RST_REPEAT_TICKS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TICKS_PER_SECOND: ticks_per_second_q <= cfg_data;
				REG_SETTLE_TICKS:     settle_ticks_q     <= cfg_data;
				REG_HOLD_TICKS:       hold_ticks_q       <= cfg_data;
				REG_REPEAT_TICKS:     repeat_ticks_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			touched_s1 <= touched;
		end
	end

	// Mode transition, then the counter action of the new mode.
	always_comb begin
		mode_d         = mode_q;
		second_count_d = second_count_q;
		settle_count_d = settle_count_q;
		hold_count_d   = hold_count_q;
		repeat_count_d = repeat_count_q;
		pulse_d        = '0;

		unique case (mode_q)
			MODE_INIT: begin
				mode_d = MODE_WAIT_FIRST;
			end
			MODE_WAIT_FIRST: begin
				if (touched_s1) begin
					mode_d = MODE_IDLE;
				end
			end
			MODE_IDLE: begin
				second_count_d = second_count_q + 8'd1;
				if (second_count_d == ticks_per_second_q) begin
					pulse_d.advance_second = 1'b1;
					second_count_d         = 8'd0;
				end
				if (touched_s1) begin
					mode_d              = MODE_SETTLE;
					pulse_d.clear_touch = 1'b1;
				end
			end
			MODE_SETTLE: begin
				if (settle_count_q == settle_ticks_q) begin
					if (touched_s1) begin
						mode_d = MODE_HOLD;
					end else begin
						mode_d            = MODE_IDLE;
						pulse_d.step_time = 1'b1;
					end
				end
			end
			MODE_HOLD: begin
				if (!touched_s1) begin
					mode_d            = MODE_IDLE;
					pulse_d.step_time = 1'b1;
				end else if (hold_count_q == hold_ticks_q) begin
					mode_d            = MODE_REPEAT_RUN;
					pulse_d.step_time = 1'b1;
				end
			end
			MODE_REPEAT_RUN: begin
				if (!touched_s1) begin
					mode_d = MODE_IDLE;
				end else if (repeat_count_q == repeat_ticks_q) begin
					mode_d = MODE_REPEAT_DUE;
				end
			end
			MODE_REPEAT_DUE: begin
				if (touched_s1) begin
					mode_d            = MODE_REPEAT_RUN;
					pulse_d.step_time = 1'b1;
				end else begin
					mode_d = MODE_IDLE;
				end
			end
			default: begin
				mode_d = MODE_INIT;
			end
		endcase

		case (mode_d)
			MODE_IDLE: begin
				settle_count_d = 8'd0;
				hold_count_d   = 8'd0;
				repeat_count_d = 8'd0;
			end
			MODE_SETTLE:     settle_count_d = settle_count_q + 8'd1;
			MODE_HOLD:       hold_count_d   = hold_count_q + 8'd1;
			MODE_REPEAT_RUN: repeat_count_d = repeat_count_q + 8'd1;
			MODE_REPEAT_DUE: repeat_count_d = 8'd0;
			default: ;
		endcase
	end

	// Controller state advances once per tick leaving stage 1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= MODE_INIT;
			second_count_q <= 8'd0;
			settle_count_q <= 8'd0;
			hold_count_q   <= 8'd0;
			repeat_count_q <= 8'd0;
		end else if (valid_s1 && adv_s1) begin
			mode_q         <= mode_d;
			second_count_q <= second_count_d;
			settle_count_q <= settle_count_d;
			hold_count_q   <= hold_count_d;
			repeat_count_q <= repeat_count_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv_s1) begin
			pulse_s2 <= pulse_d;
		end
	end

	assign out_valid      = valid_s2;
	assign advance_second = pulse_s2.advance_second;
	assign step_time      = pulse_s2.step_time;
	assign clear_touch    = pulse_s2.clear_touch;

endmodule

`default_nettype wire
